// ===== sv/hsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hsf_pkg;
  localparam int MaxStatesDefault = 8;
  localparam logic [1:0] CmdTrans = 2'd0;
  localparam logic [1:0] CmdInit  = 2'd1;
  localparam logic [1:0] CmdEmit  = 2'd2;
  localparam logic [2:0] RegNumStates = 3'd0;
  localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;

  // Saturate a 24-bit load value to 16 bits.
  function automatic logic [15:0] sat16(input logic [23:0] v);
    sat16 = (v[23:16] != 8'd0) ? 16'hFFFF : v[15:0];
  endfunction
endpackage
`default_nettype wire

// ===== sv/hsf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One cell of the mix chain: holds the previous forward value of its state and
// the transition row of that state, and adds its product to the passing sum.
module hsf_cell (
  input  wire logic        clk,
  input  wire logic        row_we,
  input  wire logic [2:0]  row_col,
  input  wire logic [15:0] row_val,
  input  wire logic        prev_we,
  input  wire logic [15:0] prev_val,
  input  wire logic        active,
  input  wire logic [2:0]  col,
  input  wire logic [34:0] sum_in,
  output logic [34:0]      sum_out
);
  logic [15:0] row_r [8];
  logic [15:0] prev_r;
  logic [31:0] prod;

  // The row is cleared at reset by the top level through a sweep of writes.
  always_ff @(posedge clk) begin
    if (row_we) row_r[row_col] <= row_val;
    if (prev_we) prev_r <= prev_val;
  end

  assign prod = prev_r * row_r[col];
  assign sum_out = active ? sum_in + {3'd0, prod} : sum_in;
endmodule
`default_nettype wire

// ===== sv/hsf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider: one quotient bit per cycle, 64-bit dividend.
module hsf_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [47:0] den,
  output logic             done,
  output logic [63:0]      quo
);
  logic [63:0] q_r, q_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [48:0] sh;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    sh = {rem_r[47:0], q_r[63]};
    if (start) begin
      q_nxt = num; rem_nxt = '0; cnt_nxt = 7'd0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den}) begin
        rem_nxt = sh - {1'b0, den};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
  end

  // The last quotient bit is formed in the final busy cycle, independent of a new start.
  assign done = busy_r && (cnt_r == 7'd63);
  assign quo = {q_r[62:0], (sh >= {1'b0, den})};
endmodule
`default_nettype wire

// ===== sv/hmm_scaled_forward_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Handshake
// in_     | input     | in_valid / in_ready, one load or emission request
// out_    | output    | out_valid / out_ready, one result per state
// cfg_    | config    | APB-style, num_states at address 0
// A load is written straight from the accepted request. An emission walks the
// partial sum along the chain of cells, one cell per cycle (skipped on a first step), then one multiply.
// The last emission of a step then runs the scale division and a normalization division
// for each state, then hands out one result per state; a zero sum skips the divisions.
// After reset a sweep clears the transition rows (reset clears the initial values);
// no request is accepted until it ends. in_ready is low while an emission works.
module hmm_scaled_forward_unit #(
  parameter int MAX_STATES = hsf_pkg::MaxStatesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [2:0]  in_from_state,
  input  wire logic [2:0]  in_to_state,
  input  wire logic [23:0] in_value,
  input  wire logic        in_first_step,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_state_index,
  output logic [15:0]      out_forward_prob,
  output logic [31:0]      out_scale_factor,
  output logic             out_zero_sum,
  output logic             out_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int NC = (MAX_STATES < 8) ? MAX_STATES : 8;
  localparam logic [3:0] NcL = 4'(NC);

  localparam logic [2:0] SClr = 3'd0, SIdle = 3'd1, SMix = 3'd2, SMul = 3'd3,
                         SScl = 3'd4, SNrm = 3'd5, SOut = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [3:0]  ns_r;
  logic [3:0]  n;
  logic [2:0]  idx_r, idx_nxt;
  logic [2:0]  to_r;
  logic [23:0] val_r;
  logic        first_r;
  logic [34:0] acc_r, acc_nxt;
  logic [47:0] a_r [8];
  logic [15:0] f_r [8];
  logic [15:0] init_r [8];
  logic [47:0] sum_r;
  logic [31:0] scale_r;
  logic        zero_r;
  logic        div_start;
  logic [63:0] div_num;
  logic        div_done;
  logic [63:0] div_quo;
  logic [34:0] chain [NC+1];
  logic [19:0] mixr;
  logic [43:0] aprod;
  logic [47:0] anew;
  logic [48:0] snew;
  logic        wr_cfg, acc_in;

  // Register and APB port.
  assign cfg_pready = 1'b1;
  assign wr_cfg = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == hsf_pkg::RegNumStates[1:0]) ? {28'd0, ns_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) ns_r <= 4'd2;
    else if (wr_cfg && cfg_paddr == hsf_pkg::RegNumStates[1:0]) ns_r <= cfg_pwdata[3:0];
  end

  always_comb begin
    n = (ns_r == 4'd0) ? 4'd1 : ns_r;
    if (n > NcL) n = NcL;
  end

  assign in_ready = (st_r == SIdle);
  assign acc_in = in_valid && in_ready;

  // Chain of cells: cell x adds prev[x]*trans[x][to] when the mix index reaches x.
  assign chain[0] = acc_r;
  for (genvar g = 0; g < NC; g++) begin : g_cell
    hsf_cell u_cell (
      .clk(clk),
      .row_we((st_r == SClr) || (acc_in && in_cmd == hsf_pkg::CmdTrans &&
              {1'b0, in_from_state} < n && {1'b0, in_to_state} < n &&
              in_from_state == 3'(g))),
      .row_col((st_r == SClr) ? idx_r : in_to_state),
      .row_val((st_r == SClr) ? 16'd0 : hsf_pkg::sat16(in_value)),
      .prev_we(st_r == SOut && out_ready && idx_r == 3'(g)),
      .prev_val(f_r[g]),
      .active(st_r == SMix && idx_r == 3'(g)),
      .col(to_r),
      .sum_in(chain[g]),
      .sum_out(chain[g+1])
    );
  end

  assign mixr = 20'((acc_r + 35'd16384) >> 15);
  assign aprod = first_r ? 44'(init_r[to_r]) * 44'(val_r) : 44'(mixr) * 44'(val_r);
  assign anew = {4'd0, aprod};
  assign snew = ((to_r == 3'd0) ? 49'd0 : {1'b0, sum_r}) + {1'b0, anew};

  assign div_start = (st_r == SMul && {1'b0, to_r} == n - 4'd1) ||
                     (st_r == SScl && div_done && !zero_r) ||
                     (st_r == SNrm && div_done && {1'b0, idx_r} != n - 4'd1);
  always_comb begin
    if (st_r == SMul) div_num = {16'd0, 48'h8000_0000_0000} + {17'd0, snew[47:1]};
    else if (st_r == SScl) div_num = {1'b0, a_r[0], 15'd0} + {17'd0, sum_r[47:1]};
    else div_num = {1'b0, a_r[idx_r + 3'd1], 15'd0} + {17'd0, sum_r[47:1]};
  end

  hsf_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
                 .den(sum_r), .done(div_done), .quo(div_quo));

  // Sequencer.
  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; acc_nxt = acc_r;
    case (st_r)
      SClr: begin
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd7) st_nxt = SIdle;
      end
      SIdle: begin
        if (acc_in && in_cmd == hsf_pkg::CmdEmit && {1'b0, in_to_state} < n) begin
          acc_nxt = '0; idx_nxt = 3'd0;
          st_nxt = in_first_step ? SMul : SMix;
        end
      end
      SMix: begin
        acc_nxt = chain[NC];
        idx_nxt = idx_r + 3'd1;
        if ({1'b0, idx_r} == n - 4'd1) st_nxt = SMul;
      end
      SMul: begin
        if ({1'b0, to_r} == n - 4'd1) begin
          st_nxt = SScl;
        end else st_nxt = SIdle;
      end
      SScl: begin
        idx_nxt = 3'd0;
        if (zero_r) st_nxt = SOut;
        else if (div_done) st_nxt = SNrm;
      end
      SNrm: begin
        if (div_done) begin
          if ({1'b0, idx_r} == n - 4'd1) begin
            st_nxt = SOut; idx_nxt = 3'd0;
          end else idx_nxt = idx_r + 3'd1;
        end
      end
      SOut: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if ({1'b0, idx_r} == n - 4'd1) st_nxt = SIdle;
        end
      end
      default: st_nxt = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SClr; idx_r <= 3'd0; sum_r <= '0;
      for (int i = 0; i < 8; i++) init_r[i] <= '0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt;
      if (acc_in && in_cmd == hsf_pkg::CmdInit && {1'b0, in_to_state} < n)
        init_r[in_to_state] <= hsf_pkg::sat16(in_value);
      if (st_r == SMul) begin
        sum_r <= (snew[48] ? hsf_pkg::Mask48 : snew[47:0]);
      end
      if (st_r == SOut && out_ready && {1'b0, idx_r} == n - 4'd1) sum_r <= '0;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (acc_in) begin
      to_r <= in_to_state; val_r <= in_value; first_r <= in_first_step;
    end
    if (st_r == SMul) begin
      a_r[to_r] <= anew;
      zero_r <= (snew == 49'd0);
      scale_r <= 32'hFFFF_FFFF;
    end
    if (st_r == SScl && div_done)
      scale_r <= (div_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_quo[31:0];
    if (st_r == SScl && zero_r)
      for (int i = 0; i < 8; i++) f_r[i] <= '0;
    if (st_r == SNrm && div_done)
      f_r[idx_r] <= (div_quo > 64'd32768) ? 16'd32768 : div_quo[15:0];
  end

  assign out_valid = (st_r == SOut);
  assign out_state_index = idx_r;
  assign out_forward_prob = f_r[idx_r];
  assign out_scale_factor = scale_r;
  assign out_zero_sum = zero_r;
  assign out_last = ({1'b0, idx_r} == n - 4'd1);
endmodule
`default_nettype wire

// ===== tb/hsf_checker.sv =====
`timescale 1ns / 1ps
module hsf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_from_state,
  input  logic [2:0]  in_to_state,
  input  logic [23:0] in_value,
  input  logic        in_first_step,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_state_index,
  input  logic [15:0] out_forward_prob,
  input  logic [31:0] out_scale_factor,
  input  logic        out_zero_sum,
  input  logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          pending
);
  import hsf_pkg::*;

  typedef struct packed {
    logic [2:0]  idx;
    logic [15:0] fwd;
    logic [31:0] scale;
    logic        zero;
    logic        last;
  } fwd_result_t;

  fwd_result_t expected_q[$];

  logic [15:0] trans_m [0:7][0:7];
  logic [15:0] init_p [0:7];
  logic [15:0] prev_f [0:7];
  logic [47:0] unnorm [0:7];
  logic [47:0] acc_sum;
  logic [3:0]  ns_reg;

  // Effective state count: zero acts as one, larger values cut to eight.
  function automatic int unsigned active_states(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return v;
  endfunction

  function automatic logic [15:0] clip16(input logic [23:0] v);
    return (v > 24'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // Forward recursion for one accepted request, queuing any results.
  task automatic forward_step(input logic [1:0] cmd, input logic [2:0] src,
                              input logic [2:0] dst, input logic [23:0] val,
                              input logic first);
    int unsigned n;
    logic [63:0] mix, a, s, scl, f, sum;
    fwd_result_t r;
    n = active_states(ns_reg);
    if (cmd == CmdTrans) begin
      if (src < n && dst < n) trans_m[src][dst] = clip16(val);
      return;
    end
    if (cmd == CmdInit) begin
      if (dst < n) init_p[dst] = clip16(val);
      return;
    end
    if (cmd != CmdEmit || dst >= n) return;
    if (first) begin
      a = 64'(init_p[dst]) * 64'(val);
    end else begin
      mix = 0;
      for (int x = 0; x < n; x++) mix += 64'(prev_f[x]) * 64'(trans_m[x][dst]);
      mix = (mix + 64'd16384) >> 15;
      a = mix * 64'(val);
    end
    if (a > 64'(Mask48)) a = 64'(Mask48);
    unnorm[dst] = a[47:0];
    if (dst == 3'd0) acc_sum = '0;
    sum = 64'(acc_sum) + a;
    acc_sum = (sum > 64'(Mask48)) ? Mask48 : sum[47:0];
    if (dst != n - 1) return;
    // Normalize the step and hand out one result per state.
    s = 64'(acc_sum);
    if (s == 0) begin
      scl = 64'hFFFF_FFFF;
    end else begin
      scl = ((64'd1 << 47) + (s >> 1)) / s;
      if (scl > 64'hFFFF_FFFF) scl = 64'hFFFF_FFFF;
    end
    for (int y = 0; y < n; y++) begin
      f = 0;
      if (s != 0) begin
        f = ((64'(unnorm[y]) << 15) + (s >> 1)) / s;
        if (f > 64'd32768) f = 64'd32768;
      end
      prev_f[y] = f[15:0];
      r.idx = y[2:0];
      r.fwd = f[15:0];
      r.scale = scl[31:0];
      r.zero = (s == 0);
      r.last = (y == n - 1);
      expected_q.push_back(r);
    end
    acc_sum = '0;
  endtask

  // Watch the channels, compare results first, then predict new requests.
  always @(posedge clk) begin
    fwd_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        for (int j = 0; j < 8; j++) trans_m[i][j] = '0;
        init_p[i] = '0;
        prev_f[i] = '0;
        unnorm[i] = '0;
      end
      acc_sum = '0;
      ns_reg = 4'd2;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == RegNumStates[1:0])
        ns_reg = cfg_pwdata[3:0];
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected result state %0d fwd %0d", out_state_index,
                     out_forward_prob);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.idx !== out_state_index || exp_r.fwd !== out_forward_prob ||
              exp_r.scale !== out_scale_factor || exp_r.zero !== out_zero_sum ||
              exp_r.last !== out_last) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: expected idx %0d fwd %0d scale %h zero %0d last %0d, got %0d %0d %h %0d %0d",
                       exp_r.idx, exp_r.fwd, exp_r.scale, exp_r.zero, exp_r.last,
                       out_state_index, out_forward_prob, out_scale_factor,
                       out_zero_sum, out_last);
          end
        end
      end
      if (in_valid && in_ready)
        forward_step(in_cmd, in_from_state, in_to_state, in_value, in_first_step);
    end
    pending = expected_q.size();
  end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import hsf_pkg::*;

  localparam int IdleLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = '0;
  logic [2:0]  in_from_state = '0;
  logic [2:0]  in_to_state = '0;
  logic [23:0] in_value = '0;
  logic        in_first_step = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_state_index;
  logic [15:0] out_forward_prob;
  logic [31:0] out_scale_factor;
  logic        out_zero_sum;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  bit          burst = 1'b0;

  // Which previous-forward and unnormalized entries hold defined values.
  logic [7:0]  prev_ok = '0;
  logic [7:0]  unorm_ok = '0;
  int unsigned n_cur = 2;

  hmm_scaled_forward_unit dut (.*);

  hsf_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before each result.
  initial begin
    int stall;
    forever begin
      stall = burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [2:0] src, input logic [2:0] dst,
                      input logic [23:0] val, input logic first);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_from_state <= src;
    in_to_state <= dst;
    in_value <= val;
    in_first_step <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Emission request that keeps track of which entries are defined.
  task automatic emit(input int unsigned y, input logic first, input logic [23:0] val);
    send(CmdEmit, 3'($urandom_range(0, 7)), y[2:0], val, first);
    unorm_ok[y] = 1'b1;
    if (y == n_cur - 1)
      for (int i = 0; i < n_cur; i++) prev_ok[i] = 1'b1;
  endtask

  // Let the block drain completely before a register write.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_states(input logic [3:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= RegNumStates[1:0];
    cfg_pwdata <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    n_cur = (v == 0) ? 1 : (v > 8) ? 8 : v;
  endtask

  function automatic logic [23:0] rand_prob();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(65536, 24'hFFFFFF));
      3: return 24'h008000;
      default: return 24'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [23:0] rand_emit();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  // Requests that the block ignores or that disturb a step in progress.
  task automatic send_noise();
    int kind;
    kind = $urandom_range(0, 4);
    if (n_cur == 8 && kind <= 1) kind = 4;
    case (kind)
      0: send(CmdEmit, 3'($urandom), 3'($urandom_range(n_cur, 7)), rand_emit(), 1'($urandom));
      1: send(CmdTrans, 3'($urandom_range(n_cur, 7)), 3'($urandom), rand_prob(), 1'($urandom));
      2: send(CmdTrans, 3'($urandom_range(0, n_cur - 1)), 3'($urandom_range(0, n_cur - 1)),
              rand_prob(), 1'($urandom));
      3: send(CmdInit, 3'($urandom), 3'($urandom_range(0, n_cur - 1)), rand_prob(),
              1'($urandom));
      default: send(2'd3, 3'($urandom), 3'($urandom), 24'($urandom), 1'($urandom));
    endcase
  endtask

  // One setting of the state count: full model load, then time steps.
  task automatic run_phase(input logic [3:0] ns_val, input bit hold);
    int items;
    int steps;
    bit first;
    bit all_prev;
    bit all_unorm;
    quiesce();
    write_states(ns_val);
    for (int i = 0; i < n_cur; i++)
      for (int j = 0; j < n_cur; j++) send(CmdTrans, i[2:0], j[2:0], rand_prob(), 1'b0);
    for (int j = 0; j < n_cur; j++) send(CmdInit, 3'd0, j[2:0], rand_prob(), 1'b0);
    items = n_cur * n_cur + n_cur;
    steps = 0;
    while (items < 40 || steps < 3) begin
      burst = ($urandom_range(0, 3) == 0);
      if (hold && steps == 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
      end
      first = ($urandom_range(0, 5) == 0);
      for (int y = 0; y < n_cur; y++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_noise();
          items++;
        end
        if ($urandom_range(0, 29) == 0) continue;
        all_prev = 1'b1;
        all_unorm = 1'b1;
        for (int x = 0; x < n_cur; x++) begin
          if (!prev_ok[x]) all_prev = 1'b0;
          if (x < y && !unorm_ok[x]) all_unorm = 1'b0;
        end
        if (y == n_cur - 1 && !all_unorm) continue;
        emit(y, (first || !all_prev) ? 1'b1 : 1'($urandom_range(0, 7) == 0), rand_emit());
        items++;
      end
      steps++;
    end
    burst = 1'b0;
  endtask

  initial begin
    logic [23:0] dvals [0:8];
    dvals = '{24'hFFFFFF, 24'd0, 24'h008000, 24'hFFFF, 24'h010000, 24'h4000,
              24'd1, 24'h7FFF, 24'h2000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: saturating loads, ignored requests, zero sum and stale entries.
    write_states(4'd3);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) send(CmdTrans, i[2:0], j[2:0], dvals[i * 3 + j], 1'b0);
    send(CmdInit, 3'd7, 3'd0, 24'hFFFFFF, 1'b0);
    send(CmdInit, 3'd0, 3'd1, 24'h008000, 1'b0);
    send(CmdInit, 3'd0, 3'd2, 24'd0, 1'b0);
    send(CmdTrans, 3'd7, 3'd5, 24'h1234, 1'b0);
    send(2'd3, 3'd7, 3'd7, 24'hFFFFFF, 1'b1);
    send(CmdEmit, 3'd0, 3'd7, 24'hFFFFFF, 1'b1);
    for (int y = 0; y < 3; y++) emit(y, 1'b1, 24'hFFFFFF);
    for (int y = 0; y < 3; y++) emit(y, 1'b0, rand_emit());
    for (int y = 0; y < 3; y++) emit(y, 1'b1, 24'd0);
    emit(0, 1'b0, 24'h010000);
    emit(2, 1'b0, 24'h00FFFF);

    // Random phases across several state counts, extremes included.
    run_phase(4'd1, 1'b0);
    run_phase(4'd8, 1'b1);
    run_phase(4'd15, 1'b0);
    run_phase(4'd0, 1'b0);
    run_phase(4'd5, 1'b0);
    run_phase(4'd2, 1'b0);
    run_phase(4'd4, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/hsf_pkg.sv
sv/hsf_cell.sv
sv/hsf_div.sv
sv/hmm_scaled_forward_unit.sv
tb/hsf_checker.sv
tb/tb_top.sv
